[design/tpr_pkg.sv]
// Shared types and constants for the token pattern replace block.
// Used by tpr_cell, tpr_out_buf and token_pattern_replace; depends on nothing.

package tpr_pkg;

  // Bytes held by each pair of pattern / replacement registers
  localparam int REG_BYTES = 16;

  // Default window depth (longest pattern supported)
  localparam int MAX_PATTERN_DEF = 16;

  // Widths of the configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_HI  = 3'd5;

  // Per-cycle control of one window cell
  typedef struct packed {
    logic load;   // take the incoming token byte
    logic shift;  // take the neighbour's byte
  } cell_ctl_t;

  // One result on its way to the output port
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_item_t;

endpackage

[design/tpr_cell.sv]
// One byte cell of the pending window: holds a byte, compares it with its
// pattern byte and hands it to the next-older neighbour on a shift.
// Depends on tpr_pkg.

module tpr_cell (
  input  logic              clk,
  input  tpr_pkg::cell_ctl_t ctl,
  input  logic [7:0]        din,
  input  logic [7:0]        nb,
  input  logic [7:0]        pat,
  output logic [7:0]        cur,
  output logic              eq
);

  logic [7:0] q;

  // Current view of the cell, including a byte loaded this cycle
  assign cur = ctl.load ? din : q;
  assign eq  = (cur == pat);

  // Hold, load or take the neighbour's byte
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q <= nb;
    end else begin
      q <= cur;
    end
  end

endmodule

[design/tpr_out_buf.sv]
// Two-entry output buffer (output register plus skid register) that parts
// the result engine from the output handshake. Depends on tpr_pkg.

module tpr_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tpr_pkg::out_item_t push_item,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output tpr_pkg::out_item_t out_item
);

  logic               head_v;
  logic               head_v_next;
  tpr_pkg::out_item_t head;
  tpr_pkg::out_item_t head_next;
  logic               skid_v;
  logic               skid_v_next;
  tpr_pkg::out_item_t skid;
  tpr_pkg::out_item_t skid_next;
  logic               pop;

  assign pop       = head_v && !out_stall;
  assign full      = skid_v;
  assign out_valid = head_v;
  assign out_item  = head;

  // Advance the head from the skid, then take the pushed transaction
  always_comb begin
    head_v_next = head_v;
    head_next   = head;
    skid_v_next = skid_v;
    skid_next   = skid;
    if (!head_v || pop) begin
      if (skid_v) begin
        head_next   = skid;
        head_v_next = 1'b1;
        skid_v_next = push;
        skid_next   = push_item;
      end else begin
        head_next   = push_item;
        head_v_next = push;
      end
    end else if (push) begin
      skid_next   = push_item;
      skid_v_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      head_v <= head_v_next;
      skid_v <= skid_v_next;
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
    skid <= skid_next;
  end

endmodule

[design/token_pattern_replace.sv]
// Token pattern replace: bytes enter the tail of a row of window cells; when
// the window is full and equals the pattern the replacement bytes are sent
// and the window empties, otherwise the oldest byte is sent, and the last
// byte of a token flushes the window. One result leaves the emit logic per
// cycle while the output buffer has room, and a byte causing several
// results (a replacement or a flush) holds the input until the run's last
// result has left the hold register. After the pattern length is lowered
// while bytes wait, the next byte may hold the input longer: a match that
// leaves bytes behind drops its pattern bytes one by one beside the
// replacement bytes, and a compare may send nothing. Results pass through a
// two-entry buffer, so the input is taken while an earlier result waits
// downstream; the engine stands still while that buffer is full. Depends on
// tpr_pkg, tpr_cell, tpr_out_buf.

module token_pattern_replace #(
  parameter int MAX_PATTERN = tpr_pkg::MAX_PATTERN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [tpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     token_byte,
  input  logic                           token_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           run_last
);

  localparam int WIN = (MAX_PATTERN < tpr_pkg::REG_BYTES) ? MAX_PATTERN
                                                          : tpr_pkg::REG_BYTES;
  localparam int CW  = $clog2(WIN + 1);
  localparam int IW  = (WIN > 1) ? $clog2(WIN) : 1;

  // Configuration registers
  logic [tpr_pkg::LEN_W-1:0] pattern_len;
  logic [tpr_pkg::LEN_W-1:0] content_len;
  logic [63:0]               pattern_lo;
  logic [63:0]               pattern_hi;
  logic [63:0]               content_lo;
  logic [63:0]               content_hi;

  // Engine state
  logic          active;
  logic          content_on;
  logic          content_next;
  logic [IW-1:0] cidx;
  logic [IW-1:0] cidx_next;
  logic [CW-1:0] drop_cnt;
  logic [CW-1:0] drop_next;
  logic [CW-1:0] n;
  logic [CW-1:0] n_next;
  logic          flush;
  logic          hold_v;
  logic          hold_v_next;
  logic [7:0]    hold_b;
  logic [7:0]    hold_b_next;

  logic                      full;
  logic                      acc;
  logic                      act;
  logic [CW-1:0]             cur_n;
  logic                      cur_flush;
  logic [tpr_pkg::LEN_W-1:0] plen_raw;
  logic [tpr_pkg::LEN_W-1:0] plen5;
  logic [tpr_pkg::LEN_W-1:0] clen5;
  logic [CW-1:0]             plen_eff;
  logic [CW-1:0]             clen_eff;
  logic [127:0]              pat_all;
  logic [127:0]              con_all;
  logic [WIN-1:0]            eq;
  logic [WIN-1:0]            in_pat;
  logic                      hit;
  logic                      shift;
  logic                      emit_v;
  logic [7:0]                emit_b;
  logic                      busy_next;
  logic                      done;
  logic                      push;
  tpr_pkg::out_item_t        push_item;
  tpr_pkg::out_item_t        out_item;
  logic [7:0]                cur_b [WIN];
  logic [7:0]                nb_b  [WIN];

  function automatic logic [7:0] pick_byte(input logic [127:0] regs,
                                           input logic [3:0]   idx);
    pick_byte = regs[{idx, 3'b000} +: 8];
  endfunction

  // Effective lengths: pattern in 1..WIN, content no longer than pattern
  assign plen_raw = (pattern_len == '0) ? 5'd1 : pattern_len;
  assign plen5    = (plen_raw > 5'(WIN)) ? 5'(WIN) : plen_raw;
  assign clen5    = (content_len > plen5) ? plen5 : content_len;
  assign plen_eff = CW'(plen5);
  assign clen_eff = CW'(clen5);
  assign pat_all  = {pattern_hi, pattern_lo};
  assign con_all  = {content_hi, content_lo};

  // Input handshake: take a byte only when no run is open, no result is held and the output buffer has room
  assign in_stall  = full || active || hold_v;
  assign acc       = in_valid && !in_stall;
  assign act       = active || acc;
  assign cur_n     = acc ? (n + CW'(1)) : n;
  assign cur_flush = acc ? token_end : flush;

  // Row of window cells, oldest byte in cell 0
  for (genvar i = 0; i < WIN; i++) begin : g_cell
    tpr_pkg::cell_ctl_t ctl;

    if (i == WIN - 1) begin : g_end
      assign nb_b[i] = 8'h00;
    end else begin : g_mid
      assign nb_b[i] = cur_b[i+1];
    end

    assign ctl.load  = acc && (n == CW'(i));
    assign ctl.shift = shift && !full;
    assign in_pat[i] = (CW'(i) < plen_eff);

    tpr_cell u_cell (
      .clk (clk),
      .ctl (ctl),
      .din (token_byte),
      .nb  (nb_b[i]),
      .pat (pat_all[8*i +: 8]),
      .cur (cur_b[i]),
      .eq  (eq[i])
    );
  end

  assign hit = &(eq | ~in_pat);

  // Emit step: replacement bytes and pending drops first, then a window
  // compare, then the end-of-token flush
  always_comb begin
    emit_v       = 1'b0;
    emit_b       = cur_b[0];
    shift        = 1'b0;
    n_next       = cur_n;
    content_next = content_on;
    cidx_next    = cidx;
    drop_next    = drop_cnt;
    if (act) begin
      if (content_on || drop_cnt != '0) begin
        if (content_on) begin
          emit_v       = 1'b1;
          emit_b       = pick_byte(con_all, 4'(cidx));
          cidx_next    = cidx + IW'(1);
          content_next = (CW'(cidx) + CW'(1)) < clen_eff;
        end
        if (drop_cnt != '0) begin
          shift     = 1'b1;
          n_next    = cur_n - CW'(1);
          drop_next = drop_cnt - CW'(1);
        end
      end else if (cur_n >= plen_eff) begin
        if (hit) begin
          if (clen_eff != '0) begin
            emit_v       = 1'b1;
            emit_b       = pick_byte(con_all, 4'd0);
            cidx_next    = IW'(1);
            content_next = CW'(1) < clen_eff;
          end
          if (cur_n == plen_eff) begin
            n_next = '0;
          end else begin
            shift     = 1'b1;
            n_next    = cur_n - CW'(1);
            drop_next = plen_eff - CW'(1);
          end
        end else begin
          emit_v = 1'b1;
          shift  = 1'b1;
          n_next = cur_n - CW'(1);
        end
      end else if (cur_flush && cur_n != '0) begin
        emit_v = 1'b1;
        shift  = 1'b1;
        n_next = cur_n - CW'(1);
      end
    end
  end

  assign busy_next = content_next || (drop_next != '0) || (n_next >= plen_eff) ||
                     (cur_flush && n_next != '0);
  assign done      = !(act && busy_next);

  // Hold the latest result until it is known whether it ends the run
  always_comb begin
    push           = 1'b0;
    push_item.data = hold_b;
    push_item.last = 1'b0;
    hold_v_next    = hold_v;
    hold_b_next    = hold_b;
    if (!full) begin
      if (emit_v) begin
        if (hold_v) begin
          push        = 1'b1;
          hold_b_next = emit_b;
        end else if (done) begin
          push           = 1'b1;
          push_item.data = emit_b;
          push_item.last = 1'b1;
        end else begin
          hold_v_next = 1'b1;
          hold_b_next = emit_b;
        end
      end else if (done && hold_v) begin
        push           = 1'b1;
        push_item.last = 1'b1;
        hold_v_next    = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      content_on <= 1'b0;
      drop_cnt   <= '0;
      n          <= '0;
      flush      <= 1'b0;
      hold_v     <= 1'b0;
    end else if (!full) begin
      active     <= act && busy_next;
      content_on <= content_next;
      drop_cnt   <= drop_next;
      n          <= n_next;
      flush      <= act && busy_next && cur_flush;
      hold_v     <= hold_v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!full) begin
      cidx   <= cidx_next;
      hold_b <= hold_b_next;
    end
  end

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len <= 5'd1;
      content_len <= '0;
      pattern_lo  <= '0;
      pattern_hi  <= '0;
      content_lo  <= '0;
      content_hi  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tpr_pkg::CFG_PATTERN_LEN: pattern_len <= cfg_data[tpr_pkg::LEN_W-1:0];
        tpr_pkg::CFG_CONTENT_LEN: content_len <= cfg_data[tpr_pkg::LEN_W-1:0];
        tpr_pkg::CFG_PATTERN_LO:  pattern_lo  <= cfg_data;
        tpr_pkg::CFG_PATTERN_HI:  pattern_hi  <= cfg_data;
        tpr_pkg::CFG_CONTENT_LO:  content_lo  <= cfg_data;
        tpr_pkg::CFG_CONTENT_HI:  content_hi  <= cfg_data;
        default: ;
      endcase
    end
  end

  tpr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign out_byte = out_item.data;
  assign run_last = out_item.last;

  // A finished run leaves fewer bytes than a pattern in the window
  a_run_end_window: assert property (@(posedge clk) disable iff (rst)
    $fell(active) |-> n < plen_eff)
    else $error("window holds a full pattern after a run ended");

  // A held result of a finished run goes out as soon as there is room
  a_hold_release: assert property (@(posedge clk) disable iff (rst)
    (!active && hold_v && !full) |=> !hold_v)
    else $error("held result not released after run end");

  // Replacement bytes are only sent within an open run
  a_content_active: assert property (@(posedge clk) disable iff (rst)
    content_on |-> active)
    else $error("replacement emission outside a run");

  // Pending drops never exceed the bytes in the window
  a_drop_bound: assert property (@(posedge clk) disable iff (rst)
    drop_cnt <= n)
    else $error("drop count exceeds window fill");

endmodule

[bench/tb_top.sv]
// Self-checking bench for token_pattern_replace: stream token bytes, predict each
// replacement run and compare every result in order. Depends on tpr_pkg and
// the token_pattern_replace RTL only.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_CYCLES = 24;    // longest run of results plus buffer slack
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int WDOG_LIMIT   = 2000;  // cycles with no transaction at all

  // Indexes past the register list; writes to them must be ignored
  localparam logic [tpr_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_6 = 3'd6;
  localparam logic [tpr_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_7 = 3'd7;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wr_en = 1'b0;
  logic [tpr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tpr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     token_byte = '0;
  logic                           token_end = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [7:0]                     out_byte;
  logic                           run_last;

  token_pattern_replace i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .token_byte (token_byte),
    .token_end  (token_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last)
  );

  // Shadow configuration and window of the replacer
  logic [tpr_pkg::LEN_W-1:0] cfg_plen;
  logic [tpr_pkg::LEN_W-1:0] cfg_clen;
  logic [63:0]               pat_lo, pat_hi, con_lo, con_hi;
  logic [7:0]                win_bytes [tpr_pkg::MAX_PATTERN_DEF];
  int                        win_count;

  tpr_pkg::out_item_t expected_q [$];

  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit hold_off_req = 1'b0;

  int fail_cnt = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int replace_cnt = 0;
  int setting_cnt = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] reg_pick(input logic [63:0] lo, input logic [63:0] hi,
                                          input int idx);
    if (idx < 8) return lo[8*idx +: 8];
    if (idx < 16) return hi[8*(idx-8) +: 8];
    return 8'h00;
  endfunction

  function automatic int eff_plen();
    int n;
    n = cfg_plen;
    if (n == 0) n = 1;
    if (n > tpr_pkg::MAX_PATTERN_DEF) n = tpr_pkg::MAX_PATTERN_DEF;
    if (n > tpr_pkg::REG_BYTES) n = tpr_pkg::REG_BYTES;
    return n;
  endfunction

  function automatic void drop_window(input int n);
    if (n >= win_count) begin
      win_count = 0;
      return;
    end
    for (int i = 0; i + n < win_count; i++) win_bytes[i] = win_bytes[i + n];
    win_count -= n;
  endfunction

  // Work out the result run caused by one accepted token byte
  function automatic void predict_replace(input logic [7:0] b, input logic last_of_token);
    int                 plen;
    int                 clen;
    bit                 hit;
    logic [7:0]         run_q [$];
    tpr_pkg::out_item_t item;
    plen = eff_plen();
    clen = (cfg_clen > plen) ? plen : cfg_clen;
    if (win_count < tpr_pkg::MAX_PATTERN_DEF) begin
      win_bytes[win_count] = b;
      win_count++;
    end
    // scan until the window is shorter than the pattern
    while (win_count >= plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++)
        if (win_bytes[i] != reg_pick(pat_lo, pat_hi, i)) hit = 1'b0;
      if (hit) begin
        for (int i = 0; i < clen; i++) run_q.push_back(reg_pick(con_lo, con_hi, i));
        drop_window(plen);
        replace_cnt++;
      end else begin
        run_q.push_back(win_bytes[0]);
        drop_window(1);
      end
    end
    // flush what is left at the end of a token
    if (last_of_token) begin
      for (int i = 0; i < win_count; i++) run_q.push_back(win_bytes[i]);
      win_count = 0;
    end
    foreach (run_q[k]) begin
      item.data = run_q[k];
      item.last = (k == run_q.size() - 1);
      expected_q.push_back(item);
    end
  endfunction

  // Check each accepted result against the oldest expectation
  initial begin : result_check
    tpr_pkg::out_item_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("unexpected result: out_byte %h run_last %b", out_byte, run_last);
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, out_byte);
            fail_cnt++;
          end
          if (run_last !== want.last) begin
            $error("run_last: expected %b, actual %b", want.last, run_last);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Drive the receiver stall: random waits per result, or one long hold-off
  initial begin : stall_drive
    int unsigned wait_cycles;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (!rst && out_valid && !out_stall && recv_idle) begin
        wait_cycles = $urandom_range(0, 8);
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet = 0;
      else quiet++;
      if (quiet >= WDOG_LIMIT) begin
        $display("token_pattern_replace test failed");
        $finish;
      end
    end
  end

  // Offer one token byte and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic last_of_token);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    token_byte <= b;
    token_end  <= last_of_token;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_replace(b, last_of_token);
    bytes_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tpr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      tpr_pkg::CFG_PATTERN_LEN: cfg_plen = val[tpr_pkg::LEN_W-1:0];
      tpr_pkg::CFG_CONTENT_LEN: cfg_clen = val[tpr_pkg::LEN_W-1:0];
      tpr_pkg::CFG_PATTERN_LO:  pat_lo = val;
      tpr_pkg::CFG_PATTERN_HI:  pat_hi = val;
      tpr_pkg::CFG_CONTENT_LO:  con_lo = val;
      tpr_pkg::CFG_CONTENT_HI:  con_hi = val;
      default: ;
    endcase
  endtask

  task automatic close_cfg();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] plen_v, input logic [63:0] clen_v,
                            input logic [63:0] plo, input logic [63:0] phi,
                            input logic [63:0] clo, input logic [63:0] chi);
    write_reg(tpr_pkg::CFG_PATTERN_LEN, plen_v);
    write_reg(tpr_pkg::CFG_CONTENT_LEN, clen_v);
    write_reg(tpr_pkg::CFG_PATTERN_LO, plo);
    write_reg(tpr_pkg::CFG_PATTERN_HI, phi);
    write_reg(tpr_pkg::CFG_CONTENT_LO, clo);
    write_reg(tpr_pkg::CFG_CONTENT_HI, chi);
    close_cfg();
    setting_cnt++;
  endtask

  // Build one token mostly from copies of the pattern, with noise between
  task automatic send_token(input int max_bytes);
    logic [7:0] tok [$];
    int         plen;
    int         kind;
    int         cut;
    int         spot;
    plen = eff_plen();
    while (tok.size() < max_bytes) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        for (int i = 0; i < plen; i++) tok.push_back(reg_pick(pat_lo, pat_hi, i));
      end else if (kind < 7) begin
        cut = $urandom_range(1, plen);
        for (int i = 0; i < cut; i++) tok.push_back(reg_pick(pat_lo, pat_hi, i));
      end else if (kind == 7) begin
        // pattern copy with one byte spoiled
        spot = $urandom_range(0, plen - 1);
        for (int i = 0; i < plen; i++)
          tok.push_back(i == spot ? 8'($urandom_range(0, 255)) : reg_pick(pat_lo, pat_hi, i));
      end else if (kind == 8) begin
        tok.push_back(reg_pick(pat_lo, pat_hi, $urandom_range(0, plen - 1)));
      end else begin
        tok.push_back(8'($urandom_range(0, 255)));
      end
    end
    // trim the token to its drawn length
    while (tok.size() > max_bytes) void'(tok.pop_back());
    foreach (tok[i]) send_byte(tok[i], i == tok.size() - 1);
  endtask

  // Reset state: one-byte pattern of zero, empty replacement, so zeros vanish
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  // Over-long replacement and zero pattern length are both clamped
  task automatic test_length_saturation();
    settle();
    set_config(64'd3, 64'd31, 64'h0000_0000_0080_FF00, '1,
               64'h0102_0304_0506_0788, 64'hFFFF_FFFF_FFFF_FFFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();
    write_reg(tpr_pkg::CFG_PATTERN_LEN, 64'd0);
    close_cfg();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // Shorten the pattern while bytes still wait in the window
  task automatic test_pattern_shrink();
    settle();
    set_config(64'd4, 64'd0, 64'h0000_0000_6463_6261, 64'd0, 64'd0, 64'd0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    settle();
    write_reg(tpr_pkg::CFG_PATTERN_LEN, 64'd2);
    close_cfg();
    send_byte(8'h63, 1'b1);
  endtask

  // Writes past the register list leave the configuration alone
  task automatic test_unmapped_index();
    settle();
    write_reg(CFG_UNMAPPED_6, '1);
    write_reg(CFG_UNMAPPED_7, '1);
    close_cfg();
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);
    send_byte(8'h71, 1'b1);
  endtask

  // One random setting: random register contents and idling, then tokens
  task automatic run_setting(input logic [4:0] plen_v, input logic [4:0] clen_v,
                             input int budget);
    logic [63:0] plen_data;
    logic [63:0] clen_data;
    int          start;
    settle();
    plen_data = {$urandom, $urandom};
    clen_data = {$urandom, $urandom};
    plen_data[4:0] = plen_v;
    clen_data[4:0] = clen_v;
    set_config(plen_data, clen_data, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
    send_idle = ($urandom_range(0, 3) != 0);
    recv_idle = ($urandom_range(0, 3) != 0);
    start = bytes_sent;
    while (bytes_sent - start < budget) send_token($urandom_range(1, 2 * eff_plen() + 4));
  endtask

  task automatic test_random_settings();
    run_setting(5'd1, 5'd0, 10);
    run_setting(5'd1, 5'd1, 10);
    run_setting(5'd16, 5'd16, 24);
    run_setting(5'd31, 5'd20, 24);
    run_setting(5'd0, 5'd0, 6);
    run_setting(5'd2, 5'd2, 10);
    repeat (4) run_setting(5'($urandom_range(1, 16)), 5'($urandom_range(0, 31)), 10);
  endtask

  // Hold the receiver off while bytes keep coming, so the input backs up
  task automatic test_backpressure();
    int start;
    settle();
    set_config(64'd2, 64'd2, {$urandom, $urandom}, 64'd0, {$urandom, $urandom}, 64'd0);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_off_req = 1'b1;
    start = bytes_sent;
    while (bytes_sent - start < 30) send_token($urandom_range(1, 8));
  endtask

  initial begin : test_seq
    // reset the shadow state along with the block
    cfg_plen = 5'd1;
    cfg_clen = '0;
    pat_lo = '0;
    pat_hi = '0;
    con_lo = '0;
    con_hi = '0;
    win_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_length_saturation();
    test_pattern_shrink();
    test_unmapped_index();
    test_random_settings();
    test_backpressure();

    settle();
    $display("Sent %0d token bytes over %0d settings; checked %0d results, %0d replacements.",
             bytes_sent, setting_cnt, results_seen, replace_cnt);
    if (fail_cnt == 0) begin
      $display("token_pattern_replace test passed");
    end else begin
      $display("token_pattern_replace test failed");
    end
    $finish;
  end

endmodule

[token_pattern_replace.f]
design/tpr_pkg.sv
design/tpr_cell.sv
design/tpr_out_buf.sv
design/token_pattern_replace.sv
bench/tb_top.sv
